/* rtl/dws_pkg.sv */
// Shared types, sizes and codes for the descriptor weight sequencer MAC.
`timescale 1ns / 1ps

package dws_pkg;

    localparam int WEIGHT_DEPTH  = 256;
    localparam int PROGRAM_DEPTH = 64;
    localparam int DATA_WIDTH    = 32;

    localparam int WA_W   = (WEIGHT_DEPTH > 2) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int PA_W   = (PROGRAM_DEPTH > 2) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WEIGHT_DEPTH + 1);
    localparam int WP_W   = ((WA_W > 8) ? WA_W : 8) + 2;
    localparam int PP_W   = 7;
    localparam int CNT_W  = 18;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_WR_W    = 2'd1;
    localparam logic [1:0] REQ_WR_DESC = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    localparam logic [1:0] KIND_GENHOLD = 2'd0;
    localparam logic [1:0] KIND_WAIT    = 2'd1;
    localparam logic [1:0] KIND_SUSPEND = 2'd2;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NOT_PROG = 3'd1;
    localparam logic [2:0] ERR_INVALID  = 3'd2;
    localparam logic [2:0] ERR_OVERRUN  = 3'd3;
    localparam logic [2:0] ERR_WIDX     = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x_count;
        logic [16:0] x_start;
        logic [16:0] y_start;
        logic [8:0]  y_step;
    } t_desc;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  addr;
        logic [31:0] weight_value;
        logic [1:0]  desc_kind;
        logic [15:0] desc_x_count;
        logic [16:0] desc_x_start;
        logic [16:0] desc_y_start;
        logic [8:0]  desc_y_step;
        logic        desc_last;
        logic [31:0] activation;
        logic [31:0] psum_in;
    } t_item;

    typedef struct packed {
        logic [31:0] weight_held;
        logic [31:0] weight_now;
        logic [6:0]  program_index;
        logic [2:0]  error_code;
        logic [31:0] access_count;
    } t_seq_res;

endpackage

/* rtl/dws_if.sv */
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface dws_in_if
    import dws_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         addr;
    logic signed [31:0] weight_value;
    logic [1:0]         desc_kind;
    logic [15:0]        desc_x_count;
    logic signed [16:0] desc_x_start;
    logic signed [16:0] desc_y_start;
    logic signed [8:0]  desc_y_step;
    logic               desc_last;
    logic signed [31:0] activation;
    logic signed [31:0] psum_in;

    modport source (
        output valid, req_type, addr, weight_value, desc_kind, desc_x_count,
               desc_x_start, desc_y_start, desc_y_step, desc_last, activation, psum_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, addr, weight_value, desc_kind, desc_x_count,
               desc_x_start, desc_y_start, desc_y_step, desc_last, activation, psum_in,
        output ready
    );
endinterface

interface dws_out_if
    import dws_pkg::*;
;
    logic               valid;
    logic               ready;
    logic signed [31:0] psum_out;
    logic signed [31:0] weight_now;
    logic [6:0]         program_index;
    logic [2:0]         error_code;
    logic [31:0]        weight_access_count;

    modport source (
        output valid, psum_out, weight_now, program_index, error_code, weight_access_count,
        input  ready
    );
    modport sink (
        input  valid, psum_out, weight_now, program_index, error_code, weight_access_count,
        output ready
    );
endinterface

/* rtl/dws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dws_mac.sv */
// Multiply-accumulate of held weight, activation and incoming partial sum.
`timescale 1ns / 1ps

module dws_mac
    import dws_pkg::*;
(
    input  logic        i_tick,
    input  logic [31:0] i_weight,
    input  logic [31:0] i_activation,
    input  logic [31:0] i_psum_in,
    output logic [31:0] o_psum_out
);

    logic signed [DATA_WIDTH-1:0] prod;
    logic signed [DATA_WIDTH-1:0] sum;

    always_comb begin
        prod = DATA_WIDTH'($signed(i_weight)) * DATA_WIDTH'($signed(i_activation));
        sum  = prod + DATA_WIDTH'($signed(i_psum_in));
        o_psum_out = i_tick ? 32'(sum) : 32'd0;
    end

endmodule

/* rtl/dws_seq.sv */
// Weight store, descriptor program and descriptor stepping state.
`timescale 1ns / 1ps

module dws_seq
    import dws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_item    i_item,
    output t_seq_res o_res
);

    logic [WCNT_W-1:0]      r_wcnt, n_wcnt;
    logic [PP_W-1:0]        r_plen, n_plen;
    logic                   r_armed, n_armed;
    logic [PP_W-1:0]        r_pp, n_pp;
    logic signed [CNT_W-1:0] r_x, n_x;
    logic signed [CNT_W-1:0] r_y, n_y;
    logic signed [WP_W-1:0] r_wp, n_wp;
    logic [31:0]            r_wreg, n_wreg;
    logic [31:0]            r_acc, n_acc;
    t_desc                  r_cur, n_cur;
    t_desc                  r_slot0, n_slot0;
    logic                   r_dhit;
    t_desc                  r_dbyp;
    logic                   r_whit;
    logic [31:0]            r_wbyp;

    t_desc                  desc_new;
    t_desc                  desc_first;
    t_desc                  d_nxt;
    logic [$bits(t_desc)-1:0] d_rdata;
    logic [31:0]            w_rdata;
    logic [31:0]            w_rd;
    logic                   dwe;
    logic                   wwe;
    logic [PA_W-1:0]        d_raddr;
    logic [WA_W-1:0]        w_raddr;
    logic [PP_W-1:0]        pp_ahead;
    logic [PP_W:0]          pp_inc;
    logic                   adv;
    logic                   wp_ok;
    logic signed [CNT_W-1:0] x_dec;
    logic signed [CNT_W-1:0] y_tmp;
    logic [2:0]             err;

    assign desc_new = '{
        kind:    i_item.desc_kind,
        x_count: i_item.desc_x_count,
        x_start: i_item.desc_x_start,
        y_start: i_item.desc_y_start,
        y_step:  i_item.desc_y_step
    };

    assign d_nxt = r_dhit ? r_dbyp : t_desc'(d_rdata);
    assign w_rd  = r_whit ? r_wbyp : w_rdata;

    always_comb begin
        n_wcnt  = r_wcnt;
        n_plen  = r_plen;
        n_armed = r_armed;
        n_pp    = r_pp;
        n_x     = r_x;
        n_y     = r_y;
        n_wp    = r_wp;
        n_wreg  = r_wreg;
        n_acc   = r_acc;
        n_cur   = r_cur;
        n_slot0 = r_slot0;
        dwe     = 1'b0;
        wwe     = 1'b0;
        adv     = 1'b0;
        err     = ERR_OK;
        x_dec   = r_x - CNT_W'(1);
        y_tmp   = r_y;
        wp_ok   = !r_wp[WP_W-1] && (WP_W'(r_wcnt) > $unsigned(r_wp));
        pp_inc  = {1'b0, r_pp} + (PP_W+1)'(1);
        desc_first = (i_item.addr == 8'd0) ? desc_new : r_slot0;

        if (i_fire) begin
            unique case (i_item.req_type)
                REQ_TICK: begin
                    if (!r_armed) begin
                        err = ERR_NOT_PROG;
                    end else if (r_pp >= r_plen) begin
                        err = ERR_OVERRUN;
                    end else begin
                        case (r_cur.kind)
                            KIND_GENHOLD: begin
                                if (!wp_ok) begin
                                    err = ERR_WIDX;
                                end else begin
                                    n_wreg = w_rd;
                                    n_x    = x_dec;
                                    if (x_dec < 0) begin
                                        n_x   = $signed({2'b00, r_cur.x_count});
                                        y_tmp = r_y - CNT_W'(1);
                                        n_wp  = r_wp + WP_W'($signed(r_cur.y_step));
                                        n_acc = r_acc + 32'd1;
                                    end
                                    n_y = y_tmp;
                                    adv = (y_tmp < 0);
                                end
                            end
                            KIND_WAIT: begin
                                n_x = x_dec;
                                adv = (x_dec < 0);
                            end
                            KIND_SUSPEND: begin
                            end
                            default: begin
                                err = ERR_INVALID;
                            end
                        endcase
                    end
                end
                REQ_WR_W: begin
                    if (int'(i_item.addr) < WEIGHT_DEPTH) begin
                        wwe = 1'b1;
                        if ((WCNT_W'(i_item.addr) + WCNT_W'(1)) > r_wcnt) begin
                            n_wcnt = WCNT_W'(i_item.addr) + WCNT_W'(1);
                        end
                        n_acc = r_acc + 32'd1;
                    end else begin
                        err = ERR_WIDX;
                    end
                end
                REQ_WR_DESC: begin
                    if (int'(i_item.addr) < PROGRAM_DEPTH) begin
                        dwe = 1'b1;
                        if (i_item.addr == 8'd0) begin
                            n_slot0 = desc_new;
                        end
                        if (i_item.desc_last) begin
                            n_plen  = PP_W'(i_item.addr) + PP_W'(1);
                            n_armed = 1'b1;
                            n_pp    = '0;
                            n_cur   = desc_first;
                            n_x     = CNT_W'($signed(desc_first.x_start));
                            n_y     = CNT_W'($signed(desc_first.y_start));
                            n_acc   = r_acc + 32'd1;
                        end else begin
                            n_armed = 1'b0;
                        end
                    end else begin
                        err = ERR_OVERRUN;
                    end
                end
                REQ_CLEAR: begin
                    n_wcnt  = '0;
                    n_plen  = '0;
                    n_armed = 1'b0;
                    n_pp    = '0;
                    n_wp    = '0;
                end
            endcase

            if (adv) begin
                n_pp = pp_inc[PP_W-1:0];
                if (pp_inc < {1'b0, r_plen}) begin
                    n_cur = d_nxt;
                    n_x   = CNT_W'($signed(d_nxt.x_start));
                    n_y   = CNT_W'($signed(d_nxt.y_start));
                end
            end
        end
    end

    assign pp_ahead = n_pp + PP_W'(1);
    assign d_raddr  = pp_ahead[PA_W-1:0];
    assign w_raddr  = n_wp[WA_W-1:0];

    dws_ram #(
        .WIDTH ($bits(t_desc)),
        .DEPTH (PROGRAM_DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (dwe),
        .i_waddr (i_item.addr[PA_W-1:0]),
        .i_wdata (desc_new),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    dws_ram #(
        .WIDTH (32),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wwe),
        .i_waddr (i_item.addr[WA_W-1:0]),
        .i_wdata (i_item.weight_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt  <= '0;
            r_plen  <= '0;
            r_armed <= 1'b0;
            r_pp    <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_wp    <= '0;
            r_wreg  <= '0;
            r_acc   <= '0;
            r_dhit  <= 1'b0;
            r_whit  <= 1'b0;
        end else begin
            r_wcnt  <= n_wcnt;
            r_plen  <= n_plen;
            r_armed <= n_armed;
            r_pp    <= n_pp;
            r_x     <= n_x;
            r_y     <= n_y;
            r_wp    <= n_wp;
            r_wreg  <= n_wreg;
            r_acc   <= n_acc;
            r_dhit  <= dwe && (i_item.addr[PA_W-1:0] == d_raddr);
            r_whit  <= wwe && (i_item.addr[WA_W-1:0] == w_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_slot0 <= n_slot0;
        r_dbyp  <= desc_new;
        r_wbyp  <= i_item.weight_value;
    end

    assign o_res = '{
        weight_held:   r_wreg,
        weight_now:    n_wreg,
        program_index: n_pp,
        error_code:    err,
        access_count:  n_acc
    };

endmodule

/* rtl/descriptor_weight_sequencer_mac.sv */
// Top level of the descriptor weight sequencer MAC processing element.
`timescale 1ns / 1ps

// Usage:
// - i_in carries one request item per valid/ready handshake: tick, weight
//   write, descriptor write (a last descriptor arms the program) or clear.
// - o_out carries exactly one result item per request: the MAC partial sum
//   (zero for non-ticks), the weight register, the active descriptor index,
//   an error code and the running weight access count.
// - Timing: an accepted item sits in the input register while the sequencer
//   and MAC compute into the output register, which holds the result valid.
// - Throughput: one item per cycle while o_out.ready is high. Weight and
//   descriptor memories are read one item ahead at the next pointer values,
//   so each tick sees its data.
// - Reset: synchronous, active low. The program is disarmed, all counters
//   and the weight register clear; memory contents are undefined until
//   written. No clearing pass; items are taken right after reset.
// - Stall: while o_out.ready is low the result holds, the input register
//   fills, and i_in.ready drops once both stages are full.

module descriptor_weight_sequencer_mac
    import dws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    dws_in_if.sink   i_in,
    dws_out_if.source o_out
);

    logic     r_in_valid;
    t_item    r_item;
    logic     r_out_valid;
    logic [31:0] r_psum;
    logic [31:0] r_weight;
    logic [6:0]  r_pindex;
    logic [2:0]  r_err;
    logic [31:0] r_acc;

    logic     fire;
    logic     in_take;
    t_seq_res seq_res;
    logic [31:0] psum;

    assign fire    = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{
                req_type:     i_in.req_type,
                addr:         i_in.addr,
                weight_value: i_in.weight_value,
                desc_kind:    i_in.desc_kind,
                desc_x_count: i_in.desc_x_count,
                desc_x_start: i_in.desc_x_start,
                desc_y_start: i_in.desc_y_start,
                desc_y_step:  i_in.desc_y_step,
                desc_last:    i_in.desc_last,
                activation:   i_in.activation,
                psum_in:      i_in.psum_in
            };
        end
        if (fire) begin
            r_psum   <= psum;
            r_weight <= seq_res.weight_now;
            r_pindex <= seq_res.program_index;
            r_err    <= seq_res.error_code;
            r_acc    <= seq_res.access_count;
        end
    end

    dws_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .o_res   (seq_res)
    );

    dws_mac u_mac (
        .i_tick       (r_item.req_type == REQ_TICK),
        .i_weight     (seq_res.weight_held),
        .i_activation (r_item.activation),
        .i_psum_in    (r_item.psum_in),
        .o_psum_out   (psum)
    );

    assign o_out.valid               = r_out_valid;
    assign o_out.psum_out            = r_psum;
    assign o_out.weight_now          = r_weight;
    assign o_out.program_index       = r_pindex;
    assign o_out.error_code          = r_err;
    assign o_out.weight_access_count = r_acc;

endmodule
